>>> rtl/kop_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kop_pkg
// Shared constants, types and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package kop_pkg;

  localparam int AngW   = 38;  // Q30 angle input to the CORDIC unit
  localparam int XyW    = 42;  // CORDIC x/y datapath
  localparam int ZW     = 36;  // CORDIC angle accumulator
  localparam int Steps  = 30;
  localparam int DivNW  = 64;  // divider dividend / quotient
  localparam int DivDW  = 32;  // divider divisor

  localparam logic [32:0] TWO_PI_Q30  = 33'd6746518852;
  localparam logic [31:0] PI_Q30      = 32'd3373259426;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [30:0] ONE_Q30     = 31'd1073741824;
  localparam logic [29:0] CORDIC_GAIN = 30'd652032874;
  localparam logic [25:0] PI_Q24      = 26'd52707179;

  localparam logic [23:0] ECC_RST   = 24'd2580000;
  localparam logic [31:0] SMA_RST   = 32'd532683162;
  localparam logic [31:0] KF_RST    = 32'd19590252;
  localparam logic [7:0]  TOL_RST   = 8'd1;
  localparam logic [7:0]  LIMIT_RST = 8'd100;

  // configuration register indexes
  localparam logic [2:0] REG_ECC   = 3'd0;
  localparam logic [2:0] REG_SMA   = 3'd1;
  localparam logic [2:0] REG_KF    = 3'd2;
  localparam logic [2:0] REG_TOL   = 3'd3;
  localparam logic [2:0] REG_LIMIT = 3'd4;

  typedef struct packed {
    logic start;
    logic vectoring;
  } cordic_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } cordic_sts_t;

  function automatic logic [29:0] atan_lut(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0:  v = 30'd843314857;
      5'd1:  v = 30'd497837829;
      5'd2:  v = 30'd263043837;
      5'd3:  v = 30'd133525159;
      5'd4:  v = 30'd67021687;
      5'd5:  v = 30'd33543516;
      5'd6:  v = 30'd16775851;
      5'd7:  v = 30'd8388438;
      5'd8:  v = 30'd4194283;
      5'd9:  v = 30'd2097149;
      default: v = 30'd1 << (5'd30 - i);  // atan(2^-i) = 2^-i at this precision
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

>>> rtl/kop_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kop_ifs
// Valid/ready channel interfaces for the mean anomaly and the solution.
// ----------------------------------------------------------------------------
interface kop_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] mean_anomaly;
  modport source (output valid, output mean_anomaly, input ready);
  modport sink   (input valid, input mean_anomaly, output ready);
endinterface

interface kop_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] eccentric_anomaly;
  logic        [31:0] radius;
  logic signed [26:0] true_anomaly;
  logic        [7:0]  iterations;
  logic               limit_reached;
  modport source (output valid, output eccentric_anomaly, output radius,
                  output true_anomaly, output iterations, output limit_reached,
                  input ready);
  modport sink   (input valid, input eccentric_anomaly, input radius,
                  input true_anomaly, input iterations, input limit_reached,
                  output ready);
endinterface
`default_nettype wire

>>> rtl/kop_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kop_cordic
// Iterative CORDIC, one micro-rotation per cycle. Rotation mode reduces the
// angle by shifted multiples of 2pi first, then folds to +-pi/2.
// ----------------------------------------------------------------------------
module kop_cordic (
  input  wire                               clk,
  input  wire                               rst_n,
  input  kop_pkg::cordic_ctl_t              ctl,
  input  wire logic signed [kop_pkg::AngW-1:0] ang_in,
  input  wire logic signed [kop_pkg::XyW-1:0]  x_in,
  input  wire logic signed [kop_pkg::XyW-1:0]  y_in,
  output kop_pkg::cordic_sts_t              sts,
  output logic signed [kop_pkg::XyW-1:0]    x_out,
  output logic signed [kop_pkg::XyW-1:0]    y_out,
  output logic signed [kop_pkg::ZW-1:0]     z_out
);
  import kop_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic              red_r, red_nxt;      // reduction phase
  logic              vec_r, vec_nxt;
  logic              neg_r, neg_nxt;
  logic              aneg_r, aneg_nxt;
  logic [4:0]        cnt_r, cnt_nxt;
  logic [AngW-1:0]   mag_r, mag_nxt;
  logic signed [XyW-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [ZW-1:0]  z_r, z_nxt;

  logic [AngW-1:0]       twopi_sh;
  logic signed [AngW:0]  rr0, rr1;
  logic signed [XyW-1:0] xsh, ysh;
  logic signed [ZW-1:0]  at;
  logic                  sigma;

  always_comb begin
    twopi_sh = AngW'(TWO_PI_Q30) << cnt_r;
    xsh      = x_r >>> cnt_r;
    ysh      = y_r >>> cnt_r;
    at       = ZW'(atan_lut(cnt_r));
    sigma    = vec_r ? y_r[XyW-1] : ~z_r[ZW-1];

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    red_nxt  = red_r;
    vec_nxt  = vec_r;
    neg_nxt  = neg_r;
    aneg_nxt = aneg_r;
    cnt_nxt  = cnt_r;
    mag_nxt  = mag_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    rr0      = '0;
    rr1      = '0;

    if (ctl.start) begin
      busy_nxt = 1'b1;
      vec_nxt  = ctl.vectoring;
      neg_nxt  = 1'b0;
      if (ctl.vectoring) begin
        red_nxt = 1'b0;
        cnt_nxt = '0;
        x_nxt   = x_in;
        y_nxt   = y_in;
        z_nxt   = '0;
      end else begin
        red_nxt  = 1'b1;
        cnt_nxt  = 5'd4;
        aneg_nxt = ang_in[AngW-1];
        mag_nxt  = ang_in[AngW-1] ? AngW'(-ang_in) : AngW'(ang_in);
      end
    end else if (busy_r && red_r) begin
      if (mag_r >= twopi_sh) begin
        mag_nxt = mag_r - twopi_sh;
      end
      if (cnt_r == 5'd0) begin
        // remainder keeps the sign of the angle, then fold into +-pi/2
        rr0 = aneg_r ? -$signed({1'b0, mag_nxt}) : $signed({1'b0, mag_nxt});
        if (rr0 > $signed((AngW+1)'(PI_Q30))) begin
          rr0 = rr0 - $signed((AngW+1)'(TWO_PI_Q30));
        end else if (rr0 < -$signed((AngW+1)'(PI_Q30))) begin
          rr0 = rr0 + $signed((AngW+1)'(TWO_PI_Q30));
        end
        rr1 = rr0;
        if (rr0 > $signed((AngW+1)'(HALF_PI_Q30))) begin
          rr1     = rr0 - $signed((AngW+1)'(PI_Q30));
          neg_nxt = 1'b1;
        end else if (rr0 < -$signed((AngW+1)'(HALF_PI_Q30))) begin
          rr1     = rr0 + $signed((AngW+1)'(PI_Q30));
          neg_nxt = 1'b1;
        end
        z_nxt   = ZW'(rr1);
        x_nxt   = XyW'(CORDIC_GAIN);
        y_nxt   = '0;
        red_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r - 5'd1;
      end
    end else if (busy_r) begin
      if (sigma) begin
        x_nxt = x_r - ysh;
        y_nxt = y_r + xsh;
        z_nxt = z_r - at;
      end else begin
        x_nxt = x_r + ysh;
        y_nxt = y_r - xsh;
        z_nxt = z_r + at;
      end
      if (cnt_r == 5'(Steps - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      red_r  <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      red_r  <= red_nxt;
      cnt_r  <= cnt_nxt;
    end
    vec_r  <= vec_nxt;
    neg_r  <= neg_nxt;
    aneg_r <= aneg_nxt;
    mag_r  <= mag_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign x_out    = neg_r ? -x_r : x_r;
  assign y_out    = neg_r ? -y_r : y_r;
  assign z_out    = z_r;

endmodule
`default_nettype wire

>>> rtl/kop_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kop_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module kop_div (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  input  wire [kop_pkg::DivNW-1:0]     dividend,
  input  wire [kop_pkg::DivDW-1:0]     divisor,
  output logic                         done,
  output logic [kop_pkg::DivNW-1:0]    quotient
);
  import kop_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [6:0]           cnt_r, cnt_nxt;
  logic [DivNW-1:0]     quo_r, quo_nxt;
  logic [DivDW-1:0]     rem_r, rem_nxt;
  logic [DivDW-1:0]     den_r, den_nxt;
  logic [DivDW:0]       rem_sh;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    rem_sh   = {rem_r, quo_r[DivNW-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      den_nxt  = divisor;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, den_r}) begin
        rem_nxt = DivDW'(rem_sh - {1'b0, den_r});
        quo_nxt = {quo_r[DivNW-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[DivDW-1:0];
        quo_nxt = {quo_r[DivNW-2:0], 1'b0};
      end
      if (cnt_r == 7'(DivNW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + 7'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

>>> rtl/kepler_orbit_position.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kepler_orbit_position
// Newton solver for Kepler's equation with radius and true anomaly.
// ----------------------------------------------------------------------------
// One transaction on in_ch carries a mean anomaly M (Q8.24 rad); one
// transaction on out_ch returns E, radius, true anomaly, the Newton step count
// and a limit flag. The solve starts from the last solution (zero after reset).
// Each residual evaluation costs one CORDIC pass (angle reduction, then the
// rotations) plus a multiply and bookkeeping; each Newton step adds a 64-bit
// restoring division. The finish costs two CORDIC passes and two multiplies.
// The time per item grows with the Newton step count and is set by the shared
// CORDIC unit and the bit-serial divider. in_ch is ready only while the solver
// is idle; a finished result sits in the output register, so the next
// transaction may be accepted before the previous result is taken.
// Configuration writes are to be made only while idle.
// ----------------------------------------------------------------------------
module kepler_orbit_position (
  input  wire        clk,
  input  wire        rst_n,
  kop_in_if.sink     in_ch,
  kop_out_if.source  out_ch,
  input  wire        cfg_we,
  input  wire [2:0]  cfg_index,
  input  wire [31:0] cfg_wdata
);
  import kop_pkg::*;

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EVAL  = 4'd1;   // launch sin/cos of E
  localparam logic [3:0] S_EWAIT = 4'd2;
  localparam logic [3:0] S_MULS  = 4'd3;   // e*sinE into multiplier
  localparam logic [3:0] S_MULC  = 4'd4;   // residual; e*cosE into multiplier
  localparam logic [3:0] S_FP    = 4'd5;   // slope
  localparam logic [3:0] S_TEST  = 4'd6;   // converge / limit test
  localparam logic [3:0] S_DWAIT = 4'd7;   // Newton division
  localparam logic [3:0] S_RAD   = 4'd8;   // a*slope into multiplier
  localparam logic [3:0] S_RAD2  = 4'd9;   // radius; launch sin/cos of E/2
  localparam logic [3:0] S_TWAIT = 4'd10;
  localparam logic [3:0] S_MULK  = 4'd11;  // k*sin into multiplier
  localparam logic [3:0] S_KAY   = 4'd12;  // launch vectoring
  localparam logic [3:0] S_VWAIT = 4'd13;
  localparam logic [3:0] S_DONE  = 4'd14;

  localparam int FW = 41;   // Q30 residual

  // configuration
  logic [23:0] ecc_r;
  logic [31:0] sma_r, kf_r;
  logic [7:0]  tol_r, limit_r;

  logic [3:0]  state_r, state_nxt;
  logic signed [31:0] prev_r, prev_nxt;
  logic signed [31:0] m_r, m_nxt;
  logic signed [31:0] e_r, e_nxt;
  logic [7:0]  iter_r, iter_nxt;
  logic signed [FW-1:0] f_r, f_nxt;
  logic signed [32:0] fp_r, fp_nxt;
  logic signed [32:0] s_r, s_nxt, c_r, c_nxt;
  logic [31:0] rad_r, rad_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic signed [31:0] oe_r, oe_nxt;
  logic [31:0] orad_r, orad_nxt;
  logic signed [26:0] oth_r, oth_nxt;
  logic [7:0]  oit_r, oit_nxt;
  logic        olim_r, olim_nxt;

  // shared multiplier, registered product
  logic [31:0]        mul_a;
  logic signed [33:0] mul_b;
  logic signed [66:0] prod_r;

  cordic_ctl_t          cctl;
  cordic_sts_t          csts;
  logic signed [AngW-1:0] c_ang;
  logic signed [XyW-1:0]  c_xin, c_yin, c_x, c_y;
  logic signed [ZW-1:0]   c_z;

  logic              div_start, div_done;
  logic [DivNW-1:0]  div_n, div_q;
  logic [DivDW-1:0]  div_d;

  logic [FW-1:0]        f_abs;
  logic                 above_tol;
  logic signed [42:0]   prod_sh;
  logic signed [65:0]   e_wide;
  logic signed [30:0]   th;
  logic [31:0]          fp_pos;

  kop_cordic u_cordic (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (cctl),
    .ang_in (c_ang),
    .x_in   (c_xin),
    .y_in   (c_yin),
    .sts    (csts),
    .x_out  (c_x),
    .y_out  (c_y),
    .z_out  (c_z)
  );

  kop_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ecc_r   <= ECC_RST;
      sma_r   <= SMA_RST;
      kf_r    <= KF_RST;
      tol_r   <= TOL_RST;
      limit_r <= LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ECC:   ecc_r   <= cfg_wdata[23:0];
        REG_SMA:   sma_r   <= cfg_wdata;
        REG_KF:    kf_r    <= cfg_wdata;
        REG_TOL:   tol_r   <= cfg_wdata[7:0];
        REG_LIMIT: limit_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // multiplier operand select
  assign fp_pos = fp_r[32] ? 32'd0 : fp_r[31:0];

  always_comb begin
    case (state_r)
      S_RAD:   mul_a = sma_r;
      S_MULK:  mul_a = kf_r;
      default: mul_a = {8'd0, ecc_r};
    endcase
    case (state_r)
      S_MULC:  mul_b = 34'(c_r);
      S_RAD:   mul_b = $signed({2'b00, fp_pos});
      default: mul_b = 34'(s_r);
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= $signed({1'b0, mul_a}) * mul_b;
  end

  assign prod_sh   = prod_r[66:24];   // floor shift by 24
  assign f_abs     = f_r[FW-1] ? FW'(-f_r) : FW'(f_r);
  assign above_tol = f_abs > FW'({tol_r, 6'd0});
  assign th        = 31'(c_z >>> 5);  // 2*z in Q30 down to Q24

  always_comb begin
    state_nxt     = state_r;
    prev_nxt      = prev_r;
    m_nxt         = m_r;
    e_nxt         = e_r;
    iter_nxt      = iter_r;
    f_nxt         = f_r;
    fp_nxt        = fp_r;
    s_nxt         = s_r;
    c_nxt         = c_r;
    rad_nxt       = rad_r;
    out_valid_nxt = out_valid_r;
    oe_nxt        = oe_r;
    orad_nxt      = orad_r;
    oth_nxt       = oth_r;
    oit_nxt       = oit_r;
    olim_nxt      = olim_r;
    cctl          = '0;
    c_ang         = '0;
    c_xin         = '0;
    c_yin         = '0;
    div_start     = 1'b0;
    div_n         = 64'(f_abs[39:0]) << 24;
    div_d         = (fp_r < 33'sd1) ? 32'd1 : fp_r[31:0];
    e_wide        = '0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          m_nxt     = in_ch.mean_anomaly;
          e_nxt     = prev_r;
          iter_nxt  = '0;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        cctl.start = 1'b1;
        c_ang      = AngW'(e_r) <<< 6;
        state_nxt  = S_EWAIT;
      end
      S_EWAIT: begin
        if (csts.done) begin
          s_nxt     = 33'(c_y);
          c_nxt     = 33'(c_x);
          state_nxt = S_MULS;
        end
      end
      S_MULS: state_nxt = S_MULC;
      S_MULC: begin
        f_nxt = (FW'(e_r) <<< 6) - FW'(prod_sh) - (FW'(m_r) <<< 6);
        state_nxt = S_FP;
      end
      S_FP: begin
        fp_nxt    = 33'($signed({1'b0, ONE_Q30}) - prod_sh);
        state_nxt = S_TEST;
      end
      S_TEST: begin
        if (above_tol && (iter_r < limit_r)) begin
          div_start = 1'b1;
          state_nxt = S_DWAIT;
        end else begin
          state_nxt = S_RAD;
        end
      end
      S_DWAIT: begin
        if (div_done) begin
          // step has the opposite sign of the residual; saturate to 32 bits
          e_wide = f_r[FW-1] ? (66'(e_r) + $signed({2'b00, div_q}))
                             : (66'(e_r) - $signed({2'b00, div_q}));
          if (e_wide > 66'sh7FFF_FFFF) begin
            e_nxt = 32'sh7FFF_FFFF;
          end else if (e_wide < -66'sh8000_0000) begin
            e_nxt = -32'sh8000_0000;
          end else begin
            e_nxt = 32'(e_wide);
          end
          iter_nxt  = iter_r + 8'd1;
          state_nxt = S_EVAL;
        end
      end
      S_RAD: state_nxt = S_RAD2;
      S_RAD2: begin
        rad_nxt    = (prod_r[66:62] != '0) ? 32'hFFFF_FFFF : prod_r[61:30];
        cctl.start = 1'b1;
        c_ang      = AngW'(e_r) <<< 5;
        state_nxt  = S_TWAIT;
      end
      S_TWAIT: begin
        if (csts.done) begin
          // keep cos(E/2) non-negative so the quotient sign is carried by sin
          s_nxt     = c_x[XyW-1] ? -33'(c_y) : 33'(c_y);
          c_nxt     = c_x[XyW-1] ? -33'(c_x) : 33'(c_x);
          state_nxt = S_MULK;
        end
      end
      S_MULK: state_nxt = S_KAY;
      S_KAY: begin
        cctl.start     = 1'b1;
        cctl.vectoring = 1'b1;
        c_xin          = XyW'(c_r);
        c_yin          = XyW'(prod_sh);
        state_nxt      = S_VWAIT;
      end
      S_VWAIT: begin
        if (csts.done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          oe_nxt        = e_r;
          orad_nxt      = rad_r;
          if (th > $signed(31'(PI_Q24))) begin
            oth_nxt = 27'(PI_Q24);
          end else if (th < -$signed(31'(PI_Q24))) begin
            oth_nxt = -27'(PI_Q24);
          end else begin
            oth_nxt = 27'(th);
          end
          oit_nxt   = iter_r;
          olim_nxt  = above_tol;
          prev_nxt  = e_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
      iter_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      prev_r      <= prev_nxt;
      out_valid_r <= out_valid_nxt;
      iter_r      <= iter_nxt;
    end
    m_r    <= m_nxt;
    e_r    <= e_nxt;
    f_r    <= f_nxt;
    fp_r   <= fp_nxt;
    s_r    <= s_nxt;
    c_r    <= c_nxt;
    rad_r  <= rad_nxt;
    oe_r   <= oe_nxt;
    orad_r <= orad_nxt;
    oth_r  <= oth_nxt;
    oit_r  <= oit_nxt;
    olim_r <= olim_nxt;
  end

  assign in_ch.ready              = (state_r == S_IDLE);
  assign out_ch.valid             = out_valid_r;
  assign out_ch.eccentric_anomaly = oe_r;
  assign out_ch.radius            = orad_r;
  assign out_ch.true_anomaly      = oth_r;
  assign out_ch.iterations        = oit_r;
  assign out_ch.limit_reached     = olim_r;

`ifndef ASSERT_OFF
  a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TEST) |-> (iter_r <= limit_r))
    else $error("step count beyond limit");

  a_cordic_free: assert property (@(posedge clk) disable iff (!rst_n)
    cctl.start |-> !csts.busy)
    else $error("CORDIC launched while busy");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> (div_d != '0))
    else $error("division by zero");

  a_step_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DWAIT && div_done) |=> (iter_r == $past(iter_r) + 8'd1))
    else $error("step count not advanced");
`endif

endmodule
`default_nettype wire
